// File: design/trimmed_mean_accumulator_defines.svh
// assertion macros shared by the block
`ifndef TRIMMED_MEAN_ACCUMULATOR_DEFINES_SVH
`define TRIMMED_MEAN_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/tma_pkg.sv
package tma_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int COUNT_BITS_DEF    = 16;
  localparam int FRACTION_BITS_DEF = 8;

  localparam int SAMPLE_W = 16;
  localparam int AVG_W    = 24;
  localparam int MODE_W   = 2;

  localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AVG = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLR = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic add;
    logic clear;
    logic load_div;
    logic step_div;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

// File: design/tma_ctrl.sv
module tma_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [tma_pkg::MODE_W-1:0]  mode,
  output logic                        in_stall,
  input  tma_pkg::status_t            st,
  output tma_pkg::cmd_t               cmd
);
  import tma_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && mode == MODE_AVG) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (mode)
            MODE_ADD: cmd.add      = 1'b1;
            MODE_AVG: cmd.load_div = 1'b1;
            MODE_CLR: cmd.clear    = 1'b1;
            default:  cmd          = '0;
          endcase
        end
      end
      S_DIV: begin
        cmd.step_div = 1'b1;
      end
      S_DONE: begin
        cmd.load_out = !st.out_busy;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: design/tma_dp.sv
module tma_dp #(
  parameter int SAMPLE_BITS   = tma_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS    = tma_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = tma_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tma_pkg::cmd_t                      cmd,
  output tma_pkg::status_t                   st,
  input  logic        [tma_pkg::SAMPLE_W-1:0] sample,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tma_pkg::AVG_W-1:0]   average,
  output logic                               had_samples,
  output logic                               count_overflowed
);
  import tma_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
  localparam int NW    = SUM_W + 1;
  localparam int DW    = NW + FRACTION_BITS;
  localparam int CNT_W = $clog2(DW);
  localparam int QW    = (DW > AVG_W) ? DW : AVG_W;

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [QW-1:0] MAG_MAX = QW'(1) << (AVG_W - 1);

  // running state
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] smin;
  logic signed [SAMPLE_BITS-1:0] smax;
  logic        [COUNT_BITS-1:0]  count;
  logic                          dropped;

  // divider state; dq holds the dividend and collects quotient bits
  logic [DW-1:0]         dq;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dsr;
  logic [CNT_W-1:0]      step_cnt;
  logic                  neg;
  logic                  had_r;
  logic                  drop_r;

  // sample bits beyond the port are zero when SAMPLE_BITS is wider
  logic        [SAMPLE_BITS+SAMPLE_W-1:0] smp_ext;
  logic signed [SAMPLE_BITS-1:0]          s;
  logic signed [NW-1:0]                   num;
  logic        [NW-1:0]                   mag;
  logic        [COUNT_BITS:0]             trial;
  logic                                   qbit;
  logic        [QW-1:0]                   q_ext;
  logic        [QW-1:0]                   q_sat;
  logic        [AVG_W-1:0]                avg_val;

  assign smp_ext = {{SAMPLE_BITS{1'b0}}, sample};
  assign s       = smp_ext[SAMPLE_BITS-1:0];

  always_comb begin
    if (count > COUNT_BITS'(2)) begin
      num = NW'(sum) - NW'(smin) - NW'(smax);
    end else begin
      num = NW'(sum);
    end
    mag = num[NW-1] ? NW'(-num) : NW'(num);
  end

  assign trial = {rem, dq[DW-1]};
  assign qbit  = trial >= {1'b0, dsr};

  always_comb begin
    q_ext = QW'(dq);
    if (neg) begin
      q_sat   = (q_ext > MAG_MAX) ? MAG_MAX : q_ext;
      avg_val = AVG_W'(-q_sat[AVG_W-1:0]);
    end else begin
      q_sat   = (q_ext > MAG_MAX - QW'(1)) ? MAG_MAX - QW'(1) : q_ext;
      avg_val = q_sat[AVG_W-1:0];
    end
  end

  assign st.div_last = step_cnt == CNT_W'(DW - 1);
  assign st.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear || cmd.load_div) begin
      sum     <= '0;
      smin    <= SMP_MAX;
      smax    <= SMP_MIN;
      count   <= '0;
      dropped <= 1'b0;
    end else if (cmd.add) begin
      if (count == '1) begin
        dropped <= 1'b1;
      end else begin
        sum   <= sum + SUM_W'(s);
        count <= count + COUNT_BITS'(1);
        if (s > smax) begin
          smax <= s;
        end
        if (s < smin) begin
          smin <= s;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_div) begin
      rem      <= '0;
      step_cnt <= '0;
      had_r    <= count != '0;
      drop_r   <= dropped;
      if (count == '0) begin
        // empty: divide zero by one
        dq  <= '0;
        dsr <= COUNT_BITS'(1);
        neg <= 1'b0;
      end else begin
        dq  <= DW'(mag) << FRACTION_BITS;
        dsr <= (count > COUNT_BITS'(2)) ? count - COUNT_BITS'(2) : count;
        neg <= num[NW-1];
      end
    end else if (cmd.step_div) begin
      rem      <= qbit ? COUNT_BITS'(trial - {1'b0, dsr}) : trial[COUNT_BITS-1:0];
      dq       <= {dq[DW-2:0], qbit};
      step_cnt <= step_cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average          <= avg_val;
      had_samples      <= had_r;
      count_overflowed <= drop_r;
    end
  end

endmodule

// File: design/trimmed_mean_accumulator.sv
// Trimmed-mean accumulator. Add-sample, clear and unused-mode items give no result and do
// not stall the input. An average item runs a restoring divider that makes one quotient
// bit per cycle over SAMPLE_BITS + COUNT_BITS + FRACTION_BITS + 1 steps (41 at the defaults),
// then moves the result into the output register once no earlier result is held there by
// out_stall; the input stalls until then, and only after that is the next item taken.
// Samples keep being accepted while a finished result waits to be taken. The average is
// signed fixed point with FRACTION_BITS fraction bits, truncated toward zero and saturated
// to 24 bits; with more than two samples the smallest and largest are left out.
`include "trimmed_mean_accumulator_defines.svh"

module trimmed_mean_accumulator #(
  parameter int SAMPLE_BITS   = tma_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS    = tma_pkg::COUNT_BITS_DEF,
  parameter int FRACTION_BITS = tma_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic        [tma_pkg::MODE_W-1:0]   mode,
  input  logic        [tma_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tma_pkg::AVG_W-1:0]    average,
  output logic                                had_samples,
  output logic                                count_overflowed
);
  import tma_pkg::*;

  cmd_t    cmd;
  status_t st;

  tma_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  tma_dp #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .COUNT_BITS    (COUNT_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .sample           (sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .average          (average),
    .had_samples      (had_samples),
    .count_overflowed (count_overflowed)
  );

  // an average request keeps the input side busy while the divider runs
  `TMA_ASSERT_NEXT(a_avg_busy, in_valid && !in_stall && mode == MODE_AVG, in_stall, "input taken during divide")

  // a new result only appears after divider work
  `TMA_ASSERT_NOW(a_result_after_div, $rose(out_valid), $past(in_stall), "result without divide")

  // empty average reads zero and cannot have dropped samples
  `TMA_ASSERT_NOW(a_empty_zero, out_valid && !had_samples, average == '0 && !count_overflowed, "empty average not zero")

endmodule

// File: test/trimmed_mean_accumulator_tb.sv
`timescale 1ns / 100ps

module trimmed_mean_accumulator_tb;
  import tma_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int unsigned COUNT_FULL = (1 << COUNT_BITS_DEF) - 1;
  localparam int SAMPLE_MAX = (1 << (SAMPLE_BITS_DEF - 1)) - 1;
  localparam int SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 64;

  typedef struct {
    logic signed [AVG_W-1:0] average;
    logic had;
    logic ovf;
  } mean_result_t;

  // running state of the accumulator and the means it owes
  class trimmed_mean_tracker;
    longint run_sum;
    int lo_seen;
    int hi_seen;
    int unsigned n_seen;
    bit dropped;
    mean_result_t expected_means[$];
    int errors;

    function new();
      clear_state();
      errors = 0;
    endfunction

    function void clear_state();
      run_sum = 0;
      lo_seen = SAMPLE_MAX;
      hi_seen = SAMPLE_MIN;
      n_seen = 0;
      dropped = 1'b0;
    endfunction

    // signed num / den in fixed point, truncated toward zero, saturated
    function logic [AVG_W-1:0] fixed_mean(longint num, longint den);
      longint lim;
      longint mag_in;
      longint q;
      longint r;
      longint mag;
      bit neg;
      lim = longint'(1) <<< (AVG_W - 1);
      neg = num < 0;
      mag_in = neg ? -num : num;
      q = mag_in / den;
      r = mag_in % den;
      if (q > (lim >>> FRACTION_BITS_DEF)) begin
        mag = lim;
      end else begin
        mag = (q <<< FRACTION_BITS_DEF) + ((r <<< FRACTION_BITS_DEF) / den);
      end
      if (neg) begin
        if (mag > lim) mag = lim;
        return AVG_W'(-mag);
      end
      if (mag > lim - 1) mag = lim - 1;
      return AVG_W'(mag);
    endfunction

    function void note_item(logic [MODE_W-1:0] m, logic [SAMPLE_W-1:0] s);
      int v;
      mean_result_t r;
      v = int'($signed(s));
      case (m)
        MODE_ADD: begin
          if (n_seen >= COUNT_FULL) begin
            dropped = 1'b1;
          end else begin
            run_sum += v;
            n_seen++;
            if (v > hi_seen) hi_seen = v;
            if (v < lo_seen) lo_seen = v;
          end
        end
        MODE_AVG: begin
          r.had = n_seen > 0;
          r.ovf = dropped;
          if (n_seen > 2) begin
            r.average = fixed_mean(run_sum - lo_seen - hi_seen, n_seen - 2);
          end else if (n_seen > 0) begin
            r.average = fixed_mean(run_sum, n_seen);
          end else begin
            r.average = '0;
          end
          expected_means.push_back(r);
          clear_state();
        end
        MODE_CLR: clear_state();
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [AVG_W-1:0] a, logic h, logic o);
      mean_result_t e;
      if (expected_means.size() == 0) begin
        $display("%0t: unexpected result, average %0d had_samples %0b count_overflowed %0b",
                 $time, a, h, o);
        errors++;
        return;
      end
      e = expected_means.pop_front();
      if (a !== e.average) begin
        $display("%0t: average mismatch, expected %0d actual %0d", $time, e.average, a);
        errors++;
      end
      if (h !== e.had) begin
        $display("%0t: had_samples mismatch, expected %0b actual %0b", $time, e.had, h);
        errors++;
      end
      if (o !== e.ovf) begin
        $display("%0t: count_overflowed mismatch, expected %0b actual %0b", $time, e.ovf, o);
        errors++;
      end
    endfunction

    function int pending();
      return expected_means.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [MODE_W-1:0] mode;
  logic [SAMPLE_W-1:0] sample;
  logic out_valid;
  logic out_stall;
  logic signed [AVG_W-1:0] average;
  logic had_samples;
  logic count_overflowed;

  trimmed_mean_tracker tracker = new();
  bit gaps_on;
  int burst_left;
  bit holdoff_req;
  int idle_cycles;
  int random_items;

  trimmed_mean_accumulator uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .sample(sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .average(average),
    .had_samples(had_samples),
    .count_overflowed(count_overflowed)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // accepted items go to the tracker, results are checked against it
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_item(mode, sample);
      if (out_valid && !out_stall) tracker.check_result(average, had_samples, count_overflowed);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
          $display("trimmed_mean_accumulator_tb: done, errors");
          $finish;
        end
      end
    end
  end

  // receiver: stall style changes on its own schedule, plus one long hold-off
  initial begin : receiver
    int rx_style;
    int style_left;
    rx_style = 0;
    style_left = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      if (style_left == 0) begin
        rx_style = $urandom_range(0, 2);
        style_left = $urandom_range(50, 300);
      end else begin
        style_left--;
      end
      case (rx_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 99) < 30);
        default: out_stall <= ($urandom_range(0, 99) < 80);
      endcase
    end
  end

  task automatic send_item(input logic [MODE_W-1:0] m, input logic [SAMPLE_W-1:0] s);
    int gap;
    in_valid <= 1'b1;
    mode <= m;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_W'(SAMPLE_MIN);
      1: return SAMPLE_W'(SAMPLE_MAX);
      2: return SAMPLE_W'($urandom_range(0, 31) - 16);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // mostly well-formed add runs closed by an average, with noise mixed in
  task automatic random_run();
    int n;
    case ($urandom_range(0, 15)) inside
      [0:4]: n = $urandom_range(0, 3);
      5: n = $urandom_range(60, 200);
      default: n = $urandom_range(4, 24);
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_item(MODE_UNUSED, SAMPLE_W'($urandom));
      end
      if ($urandom_range(0, 59) == 0) begin
        send_item(MODE_CLR, SAMPLE_W'($urandom));
        random_items++;
      end
      send_item(MODE_ADD, pick_sample());
      random_items++;
    end
    send_item(($urandom_range(0, 9) == 0) ? MODE_CLR : MODE_AVG, SAMPLE_W'($urandom));
    random_items++;
  endtask

  initial begin
    bit holdoff_done;
    bit pause_done;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_ADD;
    sample = '0;
    out_stall = 1'b0;
    holdoff_req = 1'b0;
    idle_cycles = 0;
    gaps_on = 1'b0;
    burst_left = 0;
    random_items = 0;
    holdoff_done = 1'b0;
    pause_done = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty average, single extremes, two samples, trimming, unused mode
    send_item(MODE_AVG, 16'h0000);
    send_item(MODE_ADD, 16'h8000);
    send_item(MODE_AVG, 16'h0000);
    send_item(MODE_ADD, 16'h7fff);
    send_item(MODE_AVG, 16'hffff);
    send_item(MODE_ADD, 16'h7fff);
    send_item(MODE_ADD, 16'h8000);
    send_item(MODE_AVG, 16'h0000);
    send_item(MODE_ADD, 16'h0005);
    send_item(MODE_ADD, 16'h8000);
    send_item(MODE_ADD, 16'h7fff);
    send_item(MODE_AVG, 16'h0000);
    send_item(MODE_ADD, 16'hffff);
    send_item(MODE_ADD, 16'hfffe);
    send_item(MODE_UNUSED, 16'h1234);
    send_item(MODE_ADD, 16'h0001);
    send_item(MODE_ADD, 16'hfffb);
    send_item(MODE_AVG, 16'h0000);
    send_item(MODE_ADD, 16'h0042);
    send_item(MODE_CLR, 16'h0000);
    send_item(MODE_AVG, 16'h0000);
    send_item(MODE_CLR, 16'hffff);
    send_item(MODE_UNUSED, 16'hedcb);
    send_item(MODE_AVG, 16'h0000);

    gaps_on = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      if (!holdoff_done && random_items >= 500) begin
        holdoff_done = 1'b1;
        holdoff_req = 1'b1;
      end
      if (!pause_done && random_items >= 1000) begin
        pause_done = 1'b1;
        wait_drained();
      end
      // some stretches with no sender idling
      gaps_on = ($urandom_range(0, 4) != 0);
      random_run();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("trimmed_mean_accumulator_tb: done, clean");
    end else begin
      $display("trimmed_mean_accumulator_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/tma_pkg.sv
design/tma_ctrl.sv
design/tma_dp.sv
design/trimmed_mean_accumulator.sv
test/trimmed_mean_accumulator_tb.sv
